FILE: design/nsm_pkg.sv
package nsm_pkg;

    localparam int NUM_STATES = 32;
    localparam int MASK_W     = 32;
    localparam int NUM_LIVE   = (NUM_STATES > MASK_W) ? MASK_W : NUM_STATES;
    localparam logic [MASK_W-1:0] LIVE_MASK = (NUM_LIVE >= MASK_W) ? {MASK_W{1'b1}}
                                              : MASK_W'((64'd1 << NUM_LIVE) - 64'd1);

    localparam int IDX_W     = 5;
    localparam int SYM_W     = 8;
    localparam int KIND_W    = 3;
    localparam int MEM_AW    = IDX_W + SYM_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int TBL_DEPTH = 1 << IDX_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LIVE - 1);

    localparam int IN_DATA_W  = ((IDX_W + SYM_W + MASK_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [KIND_W-1:0] KIND_LOAD_BYTE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_EPS  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_WILD = 3'd2;
    localparam logic [KIND_W-1:0] KIND_START     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BYTE      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END       = 3'd5;

    localparam logic REG_START  = 1'b0;
    localparam logic REG_ACCEPT = 1'b1;

    typedef struct packed {
        logic             clr_step;
        logic             accept;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             set_from_move;
        logic             close_step;
        logic             commit;
        logic             mark_dead;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic closed;
        logic out_valid;
    } t_status;

endpackage

FILE: design/nsm_ctrl.sv
module nsm_ctrl
    import nsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic [KIND_W-1:0] i_kind,
    input  logic              i_m_tready,
    input  t_status           i_status,
    output logic              o_s_tready,
    output t_cmd              o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOVE,
        S_DRAIN,
        S_CLOSE
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_is_byte, n_is_byte;
    logic             accept;

    // in idle, an end word waits only when the result register is full and not draining
    assign o_s_tready = (r_state == S_IDLE) &&
                        ((i_kind != KIND_END) || !i_status.out_valid || i_m_tready);
    assign accept = i_s_tvalid && o_s_tready;

    always_comb begin
        o_cmd               = '0;
        o_cmd.clr_step      = (r_state == S_CLEAR);
        o_cmd.accept        = accept;
        o_cmd.rd_en         = (r_state == S_MOVE);
        o_cmd.rd_idx        = r_cnt;
        o_cmd.set_from_move = (r_state == S_DRAIN);
        o_cmd.close_step    = (r_state == S_CLOSE) && !i_status.closed;
        o_cmd.commit        = (r_state == S_CLOSE) && i_status.closed;
        o_cmd.mark_dead     = (r_state == S_CLOSE) && i_status.closed && r_is_byte;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_is_byte = r_is_byte;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && (i_kind == KIND_START)) begin
                    n_state   = S_CLOSE;
                    n_is_byte = 1'b0;
                end else if (accept && (i_kind == KIND_BYTE)) begin
                    n_state   = S_MOVE;
                    n_cnt     = '0;
                    n_is_byte = 1'b1;
                end
            end
            S_MOVE: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_CLOSE;
            end
            S_CLOSE: begin
                if (i_status.closed) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_is_byte <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_is_byte <= n_is_byte;
        end
    end

endmodule

FILE: design/nsm_datapath.sv
module nsm_datapath
    import nsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [IDX_W-1:0]      i_state_index,
    input  logic [SYM_W-1:0]      i_byte_value,
    input  logic [MASK_W-1:0]     i_target_mask,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output t_status               o_status
);

    logic [MASK_W-1:0] r_mem [0:MEM_DEPTH-1];
    logic [MASK_W-1:0] r_mem_q;

    logic [MASK_W-1:0] r_eps  [0:TBL_DEPTH-1];
    logic [MASK_W-1:0] r_wild [0:TBL_DEPTH-1];

    logic [MASK_W-1:0] r_start, r_accept;
    logic [MASK_W-1:0] r_active;
    logic              r_dead;
    logic [MASK_W-1:0] r_set, r_acc;
    logic [SYM_W-1:0]  r_sym;
    logic              r_hit;
    logic [MEM_AW-1:0] r_clr_addr;
    logic              r_out_valid, r_out_accepted, r_out_dead;

    logic [MASK_W-1:0] eps_or, wild_or, grown, acc_next, tgt_live;
    logic              idx_ok, cfg_wr, mem_we;
    logic [MEM_AW-1:0] mem_wa;
    logic [MASK_W-1:0] mem_wd;

    assign tgt_live = i_target_mask & LIVE_MASK;
    assign idx_ok   = (int'(i_state_index) < NUM_STATES);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        unique case (paddr[APB_AW-1])
            REG_START:  prdata = r_start;
            REG_ACCEPT: prdata = r_accept;
        endcase
    end

    // one closure round and the wildcard union, across all live states at once
    always_comb begin
        eps_or  = '0;
        wild_or = '0;
        for (int s = 0; s < NUM_LIVE; s++) begin
            if (r_set[s]) begin
                eps_or = eps_or | r_eps[s];
            end
            if (r_active[s]) begin
                wild_or = wild_or | r_wild[s];
            end
        end
    end

    assign grown    = (r_set | eps_or) & LIVE_MASK;
    assign acc_next = r_acc | (r_hit ? r_mem_q : '0);

    assign mem_we = i_cmd.clr_step ||
                    (i_cmd.accept && (i_kind == KIND_LOAD_BYTE) && idx_ok);
    assign mem_wa = i_cmd.clr_step ? r_clr_addr : {i_state_index, i_byte_value};
    assign mem_wd = i_cmd.clr_step ? '0 : tgt_live;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_mem_q <= r_mem[{i_cmd.rd_idx, r_sym}];
        end
    end

    // move and closure working sets
    always_ff @(posedge i_clk) begin
        r_hit <= i_cmd.rd_en && r_active[i_cmd.rd_idx];
        if (i_cmd.accept && (i_kind == KIND_BYTE)) begin
            r_acc <= wild_or;
            r_sym <= i_byte_value;
        end else begin
            r_acc <= acc_next;
        end
        if (i_cmd.accept && (i_kind == KIND_START)) begin
            r_set <= r_start;
        end else if (i_cmd.set_from_move) begin
            r_set <= acc_next & LIVE_MASK;
        end else if (i_cmd.close_step) begin
            r_set <= grown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_accept    <= '0;
            r_active    <= '0;
            r_dead      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < TBL_DEPTH; s++) begin
                r_eps[s]  <= '0;
                r_wild[s] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[APB_AW-1])
                    REG_START:  r_start  <= pwdata & LIVE_MASK;
                    REG_ACCEPT: r_accept <= pwdata & LIVE_MASK;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.accept && (i_kind == KIND_LOAD_EPS) && idx_ok) begin
                r_eps[i_state_index] <= tgt_live;
            end
            if (i_cmd.accept && (i_kind == KIND_LOAD_WILD) && idx_ok) begin
                r_wild[i_state_index] <= tgt_live;
            end
            if (i_cmd.accept && (i_kind == KIND_START)) begin
                r_dead <= 1'b0;
            end else if (i_cmd.mark_dead && (r_set == '0)) begin
                r_dead <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_active <= r_set;
            end
            if (i_cmd.accept && (i_kind == KIND_END)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_kind == KIND_END)) begin
            r_out_accepted <= |(r_active & r_accept);
            r_out_dead     <= r_dead;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W-2){1'b0}}, r_out_dead, r_out_accepted};

    assign o_status.clr_last  = (r_clr_addr == {MEM_AW{1'b1}});
    assign o_status.closed    = (grown == r_set);
    assign o_status.out_valid = r_out_valid;

endmodule

FILE: design/nfa_string_matcher.sv
// Load and end words keep the controller idle; APB writes never wait; the end result shows the cycle after.
// Start: epsilon closure rounds run until the active set stops growing, then the set is committed.
// Byte: the transition RAM is swept one state per cycle, then closure rounds run until the set stops
// growing. The result register lets the next word in while a result waits.
// Reset is synchronous, active low; afterwards the transition RAM is cleared one entry per
// cycle with the input held off; configuration writes are taken throughout.
module nfa_string_matcher
    import nsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [4:0] state_index, [12:5] byte_value, [44:13] target_mask, rest zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // [2:0] kind
    input  logic [KIND_W-1:0]     i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] accepted, [1] went_dead, rest zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    t_cmd    cmd;
    t_status status;

    nsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    nsm_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (i_s_tuser),
        .i_state_index (i_s_tdata[IDX_W-1:0]),
        .i_byte_value  (i_s_tdata[IDX_W+SYM_W-1:IDX_W]),
        .i_target_mask (i_s_tdata[IDX_W+SYM_W+MASK_W-1:IDX_W+SYM_W]),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tdata     (o_m_tdata),
        .o_status      (status)
    );

endmodule

FILE: design/nsm_checker.sv
module nsm_checker
    import nsm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [KIND_W-1:0]     i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    logic in_acc;
    assign in_acc = i_s_tvalid && o_s_tready;

    // the RAM clear pass holds the input off right after reset
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input taken during clear pass");

    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_s_tuser == KIND_END)) |=> o_m_tvalid)
        else $error("end word gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_s_tuser != KIND_END) && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("result without end word");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind nfa_string_matcher nsm_checker u_nsm_checker (.*);

FILE: sim/testbench.sv
module testbench
    import nsm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    DRAIN_CYCLES = 80;
    localparam int    END_WAIT     = 20000;
    localparam longint WATCHDOG_NS = 20_000_000;
    localparam int    ITEM_TARGET  = 1300;

    // tuser codes the block ignores
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    typedef struct packed {
        logic went_dead;
        logic accepted;
    } t_verdict;

    // Tracks the automaton tables and active set, and queues the verdict of each end word.
    class nfa_tracker;
        logic [MASK_W-1:0] row_next  [MEM_DEPTH];
        logic [MASK_W-1:0] eps_next  [TBL_DEPTH];
        logic [MASK_W-1:0] wild_next [TBL_DEPTH];
        logic [MASK_W-1:0] live_set;
        logic [MASK_W-1:0] start_states;
        logic [MASK_W-1:0] accept_states;
        logic              dead;
        t_verdict          verdicts_due [$];
        int                errors;

        function new();
            foreach (row_next[i]) row_next[i] = '0;
            foreach (eps_next[i]) eps_next[i] = '0;
            foreach (wild_next[i]) wild_next[i] = '0;
            live_set      = '0;
            start_states  = '0;
            accept_states = '0;
            dead          = 1'b0;
            errors        = 0;
        endfunction

        function void write_mask(input logic sel, input logic [MASK_W-1:0] value);
            if (sel == REG_START) begin
                start_states = value & LIVE_MASK;
            end else begin
                accept_states = value & LIVE_MASK;
            end
        endfunction

        function logic [MASK_W-1:0] eps_closure(input logic [MASK_W-1:0] seed);
            logic [MASK_W-1:0] reach;
            logic [MASK_W-1:0] grown;
            reach = seed & LIVE_MASK;
            for (int round = 0; round <= MASK_W; round++) begin
                grown = reach;
                for (int s = 0; s < MASK_W; s++) begin
                    if (reach[s]) grown |= eps_next[s];
                end
                grown &= LIVE_MASK;
                if (grown == reach) break;
                reach = grown;
            end
            return reach;
        endfunction

        function void note_word(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                                input logic [SYM_W-1:0] sym, input logic [MASK_W-1:0] tgt);
            logic [MASK_W-1:0] kept;
            logic [MASK_W-1:0] moved;
            logic              idx_ok;
            t_verdict          v;
            kept   = tgt & LIVE_MASK;
            idx_ok = int'(idx) < NUM_STATES;
            case (kind)
                KIND_LOAD_BYTE: begin
                    if (idx_ok) row_next[{idx, sym}] = kept;
                end
                KIND_LOAD_EPS: begin
                    if (idx_ok) eps_next[idx] = kept;
                end
                KIND_LOAD_WILD: begin
                    if (idx_ok) wild_next[idx] = kept;
                end
                KIND_START: begin
                    live_set = eps_closure(start_states);
                    dead     = 1'b0;
                end
                KIND_BYTE: begin
                    moved = '0;
                    for (int s = 0; s < MASK_W; s++) begin
                        if (live_set[s]) moved |= row_next[{IDX_W'(s), sym}] | wild_next[s];
                    end
                    live_set = eps_closure(moved & LIVE_MASK);
                    if (live_set == '0) dead = 1'b1;
                end
                KIND_END: begin
                    v.accepted  = |(live_set & accept_states);
                    v.went_dead = dead;
                    verdicts_due.push_back(v);
                end
                default: ;
            endcase
        endfunction

        function void check_word(input logic [OUT_DATA_W-1:0] word);
            t_verdict want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: result word %h arrived with no end word waiting", $time, word);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (word[0] !== want.accepted) begin
                $display("%0t: accepted expected %0d got %0d", $time, want.accepted, word[0]);
                errors++;
            end
            if (word[1] !== want.went_dead) begin
                $display("%0t: went_dead expected %0d got %0d", $time, want.went_dead, word[1]);
                errors++;
            end
            if (word[OUT_DATA_W-1:2] !== '0) begin
                $display("%0t: upper result bits expected 0 got %h", $time,
                         word[OUT_DATA_W-1:2]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [4:0] state_index, [12:5] byte_value, [44:13] target_mask, rest zero
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    // [2:0] kind
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] accepted, [1] went_dead, rest zero
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_AW-1:0]     paddr    = '0;
    logic [APB_DW-1:0]     pwdata   = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    nfa_tracker tracker = new();

    int src_mode  = 1;
    int sink_mode = 1;
    int sink_hold = 0;
    int words_sent = 0;
    logic [SYM_W-1:0] alphabet [3];

    nfa_string_matcher DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len(input int mode);
        int roll;
        if (mode == 0) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Mostly a few target states at or below top, sometimes none, all or random.
    function automatic logic [MASK_W-1:0] pick_mask(input int top);
        logic [MASK_W-1:0] m;
        int                roll;
        m    = '0;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 12) return '1;
        if (roll < 20) return $urandom();
        repeat ($urandom_range(1, 3)) m[$urandom_range(0, top)] = 1'b1;
        return m;
    endfunction

    function automatic logic [SYM_W-1:0] pick_symbol();
        if ($urandom_range(0, 99) < 85) return alphabet[$urandom_range(0, 2)];
        return SYM_W'($urandom());
    endfunction

    function automatic logic [KIND_W-1:0] spare_kind();
        return $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    endfunction

    // Stall the result side at random.
    always @(negedge clk) begin
        if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) sink_hold = gap_len(sink_mode);
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) tracker.check_word(m_tdata);
    end

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                             input logic [SYM_W-1:0] sym, input logic [MASK_W-1:0] tgt);
        int gap;
        gap = gap_len(src_mode);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_DATA_W'({tgt, sym, idx});
        do @(posedge clk); while (!s_tready);
        tracker.note_word(kind, idx, sym, tgt);
        if (kind <= KIND_END) words_sent++;
    endtask

    // Write a mask register, then read it back.
    task automatic set_mask(input logic sel, input logic [MASK_W-1:0] value);
        logic [MASK_W-1:0] want;
        want = value & LIVE_MASK;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_mask(sel, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %0d read expected %h got %h", $time, sel, want, prdata);
            tracker.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid, wait for every verdict, then let a byte still in flight finish.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.verdicts_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic directed_words();
        set_mask(REG_START, 32'h0000_0001);
        set_mask(REG_ACCEPT, 32'h8000_0000);
        // byte before any start leaves the set empty
        send_word(KIND_BYTE, '0, 8'hFF, '0);
        send_word(KIND_END, '0, '0, '0);
        send_word(KIND_LOAD_BYTE, 5'd0, 8'hFF, 32'h8000_0000);
        send_word(KIND_LOAD_BYTE, 5'd31, 8'h00, 32'hFFFF_FFFF);
        send_word(KIND_LOAD_EPS, 5'd31, 8'h00, 32'h0000_0001);
        send_word(KIND_LOAD_WILD, 5'd0, 8'h00, 32'h0000_0000);
        send_word(KIND_SPARE_A, '0, '0, '0);
        send_word(KIND_START, '0, '0, '0);
        send_word(KIND_BYTE, '0, 8'hFF, '0);
        send_word(KIND_END, '0, '0, '0);
        send_word(KIND_BYTE, '1, 8'h00, '1);
        send_word(KIND_END, '1, '1, '1);
        // no row for this symbol: the set dies and stays dead
        send_word(KIND_BYTE, '0, 8'h80, '0);
        send_word(KIND_END, '0, '0, '0);
        send_word(KIND_BYTE, '0, 8'h00, '0);
        send_word(KIND_END, '0, '0, '0);
        send_word(KIND_END, '0, '0, '0);
        send_word(KIND_SPARE_B, '1, '1, '1);
        send_word(KIND_START, '1, '1, '1);
        send_word(KIND_END, '0, '0, '0);
        send_word(KIND_LOAD_WILD, 5'd0, 8'h00, 32'h8000_0000);
        send_word(KIND_BYTE, '0, 8'h5A, '0);
        send_word(KIND_END, '0, '0, '0);
        send_word(KIND_LOAD_WILD, 5'd0, 8'h00, '0);
        send_word(KIND_LOAD_EPS, 5'd31, 8'h00, '0);
        settle();
    endtask

    // Epsilon chain through every state: the closure needs all rounds.
    task automatic chain_phase();
        set_mask(REG_START, 32'h0000_0001);
        set_mask(REG_ACCEPT, $urandom_range(0, 1) ? 32'h8000_0000 : pick_mask(31));
        for (int s = 0; s < NUM_STATES; s++) begin
            send_word(KIND_LOAD_EPS, IDX_W'(s), SYM_W'($urandom()),
                      (s == NUM_STATES - 1) ? '0 : (MASK_W'(1) << (s + 1)));
        end
        send_word(KIND_START, IDX_W'($urandom()), SYM_W'($urandom()), $urandom());
        repeat ($urandom_range(0, 3)) begin
            send_word(KIND_BYTE, IDX_W'($urandom()), SYM_W'($urandom()), $urandom());
        end
        send_word(KIND_END, IDX_W'($urandom()), SYM_W'($urandom()), $urandom());
        send_word(KIND_START, IDX_W'($urandom()), SYM_W'($urandom()), $urandom());
        send_word(KIND_END, IDX_W'($urandom()), SYM_W'($urandom()), $urandom());
        for (int s = NUM_STATES - 1; s >= 0; s--) begin
            send_word(KIND_LOAD_EPS, IDX_W'(s), SYM_W'($urandom()), '0);
        end
    endtask

    task automatic string_phase(input int top);
        int roll;
        repeat ($urandom_range(2, 10)) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                send_word(KIND_LOAD_BYTE, IDX_W'($urandom_range(0, top)), pick_symbol(),
                          pick_mask(top));
            end else if (roll < 88) begin
                send_word(KIND_LOAD_EPS, IDX_W'($urandom_range(0, top)), SYM_W'($urandom()),
                          $urandom_range(0, 1) ? '0 : pick_mask(top));
            end else begin
                send_word(KIND_LOAD_WILD, IDX_W'($urandom_range(0, top)), SYM_W'($urandom()),
                          $urandom_range(0, 1) ? '0 : pick_mask(top));
            end
        end
        repeat ($urandom_range(1, 3)) begin
            // now and then run a string on the leftover set
            if ($urandom_range(0, 19) != 0) begin
                send_word(KIND_START, IDX_W'($urandom()), SYM_W'($urandom()), $urandom());
            end
            repeat ($urandom_range(0, 10)) begin
                if ($urandom_range(0, 39) == 0) begin
                    send_word(spare_kind(), IDX_W'($urandom()), SYM_W'($urandom()),
                              $urandom());
                end
                send_word(KIND_BYTE, IDX_W'($urandom()), pick_symbol(), $urandom());
            end
            send_word(KIND_END, IDX_W'($urandom()), SYM_W'($urandom()), $urandom());
            if ($urandom_range(0, 29) == 0) begin
                send_word(KIND_END, IDX_W'($urandom()), SYM_W'($urandom()), '1);
            end
        end
    endtask

    task automatic noise_phase();
        repeat ($urandom_range(10, 25)) begin
            send_word(KIND_W'($urandom_range(0, 7)), IDX_W'($urandom()), SYM_W'($urandom()),
                      pick_mask(31));
        end
    endtask

    task automatic random_phase(input bit first);
        int top;
        int pick;
        top  = ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(2, 12);
        pick = $urandom_range(0, 99);
        foreach (alphabet[i]) alphabet[i] = SYM_W'($urandom());
        src_mode  = ($urandom_range(0, 3) == 0) ? 0 : 1;
        sink_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
        if (pick < 4) begin
            chain_phase();
        end else begin
            if (first || $urandom_range(0, 9) < 7) set_mask(REG_START, pick_mask(top));
            if (first || $urandom_range(0, 9) < 7) set_mask(REG_ACCEPT, pick_mask(top));
            if (pick < 12) begin
                noise_phase();
            end else begin
                string_phase(top);
            end
        end
        settle();
    endtask

    initial begin
        int waited;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        directed_words();
        random_phase(1'b1);
        while (words_sent < ITEM_TARGET) random_phase(1'b0);
        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (tracker.verdicts_due.size() != 0 && waited < END_WAIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.verdicts_due.size() != 0) begin
            $display("%0t: %0d verdicts expected but never arrived", $time,
                     tracker.verdicts_due.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("%0t: run did not finish in time", $time);
        $display("testbench failed");
        $finish;
    end

endmodule
